@@ rtl/floor_ceiling_texel_mapper_macros.svh @@
`ifndef FLOOR_CEILING_TEXEL_MAPPER_MACROS_SVH
`define FLOOR_CEILING_TEXEL_MAPPER_MACROS_SVH

// same-cycle implication
`define FCTM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FCTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fctm_pkg.sv @@
`timescale 1ns / 1ps
package fctm_pkg;

  localparam int DISPLAY_COLS = 1024;
  localparam int TEX_SIZE     = 256;

  localparam int ROW_W  = 10;
  localparam int COL_W  = 10;
  localparam int TEX_W  = 8;
  localparam int DIST_W = 32;

  // screen width is a power of two, so the column divide is a shift
  localparam int SW_LOG2   = $clog2(DISPLAY_COLS);
  localparam int OFF_SHIFT = SW_LOG2 + 14;

  localparam int DN_W    = 29;
  localparam int PROD_W  = 62;
  localparam int OFF_W   = PROD_W - OFF_SHIFT;
  localparam int WORLD_W = OFF_W + 1;

  localparam logic [PROD_W-1:0] OFF_BIAS = (PROD_W'(1) << OFF_SHIFT) - PROD_W'(1);

  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIST_W / DIV_STEPS;

  typedef enum logic [2:0] {
    REG_POS_X,
    REG_POS_Y,
    REG_EYE_SCALE,
    REG_HORIZON_ROW,
    REG_LEFT_DIR_X,
    REG_LEFT_DIR_Y,
    REG_SPAN_X,
    REG_SPAN_Y
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        eye_scale;
    logic [9:0]         horizon_row;
    logic signed [15:0] left_dir_x;
    logic signed [15:0] left_dir_y;
    logic signed [16:0] span_x;
    logic signed [16:0] span_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pos_x:       32'sd0,
    pos_y:       32'sd0,
    eye_scale:   32'd65536,
    horizon_row: 10'd512,
    left_dir_x:  16'sd16384,
    left_dir_y:  16'sd0,
    span_x:      17'sd0,
    span_y:      17'sd0
  };

  typedef struct packed {
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic                   ceiling;
    logic                   at_h;
    logic signed [DN_W-1:0] dnx;
    logic signed [DN_W-1:0] dny;
  } pix_t;

  // fraction of |w| scaled to the texture, with the wrap at TEX_SIZE - 1
  function automatic logic [TEX_W-1:0] texel_of(input logic [WORLD_W-1:0] w);
    logic [15:0] mag;
    logic [31:0] scaled;
    logic [15:0] t;
    mag    = w[WORLD_W-1] ? 16'(-w[15:0]) : w[15:0];
    scaled = 32'(mag) * 32'(TEX_SIZE);
    t      = scaled[31:16];
    if (t == 16'(TEX_SIZE - 1)) begin
      t = 16'd0;
    end
    return TEX_W'(t);
  endfunction

endpackage

@@ rtl/fctm_front.sv @@
`timescale 1ns / 1ps
module fctm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [fctm_pkg::ROW_W-1:0]    pixel_row,
  input  logic [fctm_pkg::COL_W-1:0]    pixel_col,
  input  fctm_pkg::cfg_t                cfg,
  output logic                          v,
  output fctm_pkg::pix_t                pix,
  output logic [fctm_pkg::ROW_W-1:0]    ad
);

  logic signed [fctm_pkg::ROW_W:0]  d;
  logic [fctm_pkg::ROW_W-1:0]       ad_next;
  fctm_pkg::pix_t                   pix_next;

  always_comb begin
    d = $signed({1'b0, pixel_row}) - $signed({1'b0, cfg.horizon_row});
    ad_next = d[fctm_pkg::ROW_W] ? fctm_pkg::ROW_W'(-d) : d[fctm_pkg::ROW_W-1:0];
    pix_next.row     = pixel_row;
    pix_next.col     = pixel_col;
    pix_next.ceiling = d[fctm_pkg::ROW_W];
    pix_next.at_h    = (d == '0);
    // ray direction numerator: left_dir * width + col * span
    pix_next.dnx = (fctm_pkg::DN_W'(cfg.left_dir_x) <<< fctm_pkg::SW_LOG2)
                 + fctm_pkg::DN_W'($signed({1'b0, pixel_col})) * fctm_pkg::DN_W'(cfg.span_x);
    pix_next.dny = (fctm_pkg::DN_W'(cfg.left_dir_y) <<< fctm_pkg::SW_LOG2)
                 + fctm_pkg::DN_W'($signed({1'b0, pixel_col})) * fctm_pkg::DN_W'(cfg.span_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
    if (en) begin
      pix <= pix_next;
      ad  <= ad_next;
    end
  end

endmodule

@@ rtl/fctm_div.sv @@
`timescale 1ns / 1ps
module fctm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  fctm_pkg::pix_t                in_pix,
  input  logic [fctm_pkg::ROW_W-1:0]    ad,
  input  logic [fctm_pkg::DIST_W-1:0]   eye_scale,
  output logic                          out_v,
  output fctm_pkg::pix_t                out_pix,
  output logic [fctm_pkg::DIST_W-1:0]   ray_len
);

  localparam int N = fctm_pkg::DIV_STAGES;

  logic                          sv   [N+1];
  fctm_pkg::pix_t                spix [N+1];
  logic [fctm_pkg::ROW_W-1:0]    sad  [N+1];
  logic [fctm_pkg::ROW_W-1:0]    srem [N+1];
  logic [fctm_pkg::DIST_W-1:0]   snum [N+1];

  assign sv[0]   = in_v;
  assign spix[0] = in_pix;
  assign sad[0]  = ad;
  assign srem[0] = '0;
  assign snum[0] = eye_scale;

  // restoring division, DIV_STEPS quotient bits per stage; quotient shifts in
  // at the bottom of snum as dividend bits leave the top
  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [fctm_pkg::ROW_W-1:0]  rem_next;
    logic [fctm_pkg::DIST_W-1:0] num_next;

    always_comb begin
      logic [fctm_pkg::ROW_W:0] r;
      logic                     q;
      rem_next = srem[g];
      num_next = snum[g];
      for (int k = 0; k < fctm_pkg::DIV_STEPS; k++) begin
        r = {rem_next, num_next[fctm_pkg::DIST_W-1]};
        q = (r >= {1'b0, sad[g]});
        if (q) begin
          r = r - {1'b0, sad[g]};
        end
        rem_next = r[fctm_pkg::ROW_W-1:0];
        num_next = {num_next[fctm_pkg::DIST_W-2:0], q};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g+1] <= 1'b0;
      end else if (en) begin
        sv[g+1] <= sv[g];
      end
      if (en) begin
        spix[g+1] <= spix[g];
        sad[g+1]  <= sad[g];
        srem[g+1] <= rem_next;
        snum[g+1] <= num_next;
      end
    end
  end

  assign out_v   = sv[N];
  assign out_pix = spix[N];
  assign ray_len = snum[N];

endmodule

@@ rtl/fctm_proj.sv @@
`timescale 1ns / 1ps
module fctm_proj (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  fctm_pkg::pix_t                in_pix,
  input  logic [fctm_pkg::DIST_W-1:0]   ray_len,
  input  logic signed [31:0]            pos_x,
  input  logic signed [31:0]            pos_y,
  output logic                          out_valid,
  output logic [fctm_pkg::ROW_W-1:0]    out_row,
  output logic [fctm_pkg::COL_W-1:0]    out_col,
  output logic [fctm_pkg::TEX_W-1:0]    texel_x,
  output logic [fctm_pkg::TEX_W-1:0]    texel_y,
  output logic                          is_ceiling,
  output logic                          at_horizon
);

  localparam int PW = fctm_pkg::PROD_W;
  localparam int OW = fctm_pkg::OFF_W;
  localparam int WW = fctm_pkg::WORLD_W;

  // product stage
  logic                  vm;
  fctm_pkg::pix_t        pm;
  logic signed [PW-1:0]  prod_x;
  logic signed [PW-1:0]  prod_y;
  // offset stage
  logic                  vo;
  fctm_pkg::pix_t        po;
  logic signed [OW-1:0]  off_x;
  logic signed [OW-1:0]  off_y;
  // world stage
  logic                  vw;
  fctm_pkg::pix_t        pw;
  logic [WW-1:0]         world_x;
  logic [WW-1:0]         world_y;

  logic signed [PW-1:0]  rnd_x;
  logic signed [PW-1:0]  rnd_y;

  // truncation toward zero: bias negative products before the shift
  always_comb begin
    rnd_x = prod_x[PW-1] ? prod_x + fctm_pkg::OFF_BIAS : prod_x;
    rnd_y = prod_y[PW-1] ? prod_y + fctm_pkg::OFF_BIAS : prod_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= 1'b0;
      vo        <= 1'b0;
      vw        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vm        <= in_v;
      vo        <= vm;
      vw        <= vo;
      out_valid <= vw;
    end
    if (en) begin
      pm     <= in_pix;
      prod_x <= PW'($signed({1'b0, ray_len})) * PW'(in_pix.dnx);
      prod_y <= PW'($signed({1'b0, ray_len})) * PW'(in_pix.dny);

      po    <= pm;
      off_x <= rnd_x[PW-1:fctm_pkg::OFF_SHIFT];
      off_y <= rnd_y[PW-1:fctm_pkg::OFF_SHIFT];

      pw      <= po;
      world_x <= WW'(pos_x) + WW'(off_x);
      world_y <= WW'(pos_y) - WW'(off_y);

      out_row    <= pw.row;
      out_col    <= pw.col;
      is_ceiling <= pw.ceiling;
      at_horizon <= pw.at_h;
      texel_x    <= pw.at_h ? '0 : fctm_pkg::texel_of(world_x);
      texel_y    <= pw.at_h ? '0 : fctm_pkg::texel_of(world_y);
    end
  end

endmodule

@@ rtl/floor_ceiling_texel_mapper.sv @@
`timescale 1ns / 1ps
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_stall  | pixel_row, pixel_col
// out      | out_valid / out_stall| out_row, out_col, texel_x, texel_y,
//          |                      | is_ceiling, at_horizon
// cfg      | apb psel/penable     | paddr, pwrite, pwdata, prdata, pready
//
// one pixel per cycle sustained while out_stall is low; registers in order: 1 front, 8
// divider stages of 4 quotient bits each, product, offset, world sum, output register
// the 32 by 10 bit distance divide sets the pipeline depth
// rst is synchronous: clears valid bits and loads register defaults
// a stalled output freezes the whole pipeline; in_stall follows at once
`include "floor_ceiling_texel_mapper_macros.svh"
module floor_ceiling_texel_mapper (
  input  logic                          clk,
  input  logic                          rst,
  // pixel requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fctm_pkg::ROW_W-1:0]    pixel_row,
  input  logic [fctm_pkg::COL_W-1:0]    pixel_col,
  // texel results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fctm_pkg::ROW_W-1:0]    out_row,
  output logic [fctm_pkg::COL_W-1:0]    out_col,
  output logic [fctm_pkg::TEX_W-1:0]    texel_x,
  output logic [fctm_pkg::TEX_W-1:0]    texel_y,
  output logic                          is_ceiling,
  output logic                          at_horizon,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  fctm_pkg::cfg_t                    cfg;
  fctm_pkg::reg_idx_t                reg_idx;
  logic                              en;

  logic                              v1;
  fctm_pkg::pix_t                    pix1;
  logic [fctm_pkg::ROW_W-1:0]        ad1;
  logic                              vd;
  fctm_pkg::pix_t                    pixd;
  logic [fctm_pkg::DIST_W-1:0]       ray_len;

  // the whole pipeline advances unless a finished result is held back
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- register file ----------------
  assign pready  = 1'b1;
  assign reg_idx = fctm_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= fctm_pkg::CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        fctm_pkg::REG_POS_X:       cfg.pos_x       <= pwdata;
        fctm_pkg::REG_POS_Y:       cfg.pos_y       <= pwdata;
        fctm_pkg::REG_EYE_SCALE:   cfg.eye_scale   <= pwdata;
        fctm_pkg::REG_HORIZON_ROW: cfg.horizon_row <= pwdata[9:0];
        fctm_pkg::REG_LEFT_DIR_X:  cfg.left_dir_x  <= pwdata[15:0];
        fctm_pkg::REG_LEFT_DIR_Y:  cfg.left_dir_y  <= pwdata[15:0];
        fctm_pkg::REG_SPAN_X:      cfg.span_x      <= pwdata[16:0];
        fctm_pkg::REG_SPAN_Y:      cfg.span_y      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // readback returns the raw register bits, zero extended
  always_comb begin
    case (reg_idx)
      fctm_pkg::REG_POS_X:       prdata = cfg.pos_x;
      fctm_pkg::REG_POS_Y:       prdata = cfg.pos_y;
      fctm_pkg::REG_EYE_SCALE:   prdata = cfg.eye_scale;
      fctm_pkg::REG_HORIZON_ROW: prdata = 32'(cfg.horizon_row);
      fctm_pkg::REG_LEFT_DIR_X:  prdata = 32'(unsigned'(cfg.left_dir_x));
      fctm_pkg::REG_LEFT_DIR_Y:  prdata = 32'(unsigned'(cfg.left_dir_y));
      fctm_pkg::REG_SPAN_X:      prdata = 32'(unsigned'(cfg.span_x));
      fctm_pkg::REG_SPAN_Y:      prdata = 32'(unsigned'(cfg.span_y));
      default:                   prdata = '0;
    endcase
  end

  // ---------------- pipeline ----------------
  // front: row vs horizon, |row - horizon|, ray direction numerators
  fctm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .pixel_row (pixel_row),
    .pixel_col (pixel_col),
    .cfg       (cfg),
    .v         (v1),
    .pix       (pix1),
    .ad        (ad1)
  );

  // distance = eye_scale / |row - horizon|
  fctm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_v      (v1),
    .in_pix    (pix1),
    .ad        (ad1),
    .eye_scale (cfg.eye_scale),
    .out_v     (vd),
    .out_pix   (pixd),
    .ray_len   (ray_len)
  );

  // distance times direction, world point, texel lookup, output register
  fctm_proj u_proj (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_v       (vd),
    .in_pix     (pixd),
    .ray_len    (ray_len),
    .pos_x      (cfg.pos_x),
    .pos_y      (cfg.pos_y),
    .out_valid  (out_valid),
    .out_row    (out_row),
    .out_col    (out_col),
    .texel_x    (texel_x),
    .texel_y    (texel_y),
    .is_ceiling (is_ceiling),
    .at_horizon (at_horizon)
  );

  // ---------------- checks ----------------
  `FCTM_ASSERT_NOW(a_horizon_zero, clk, rst, out_valid && at_horizon, texel_x == '0 && texel_y == '0, "horizon row with nonzero texel")
  `FCTM_ASSERT_NOW(a_horizon_floor, clk, rst, out_valid && at_horizon, !is_ceiling, "horizon row marked ceiling")
  `FCTM_ASSERT_NOW(a_texel_wrap, clk, rst, out_valid, texel_x != fctm_pkg::TEX_W'(fctm_pkg::TEX_SIZE - 1) && texel_y != fctm_pkg::TEX_W'(fctm_pkg::TEX_SIZE - 1), "texel not wrapped")
  `FCTM_ASSERT_NEXT(a_stall_freeze, clk, rst, out_valid && out_stall, $stable(pix1) && $stable(ray_len), "pipeline moved during stall")

endmodule
